// File: hw/rtl/lshg_pkg.sv
// Shared constants, types and codes of the grid shift vector hash.
// Used by every module of the block; depends on nothing else.
package lshg_pkg;

   // Block sizing.
   localparam int NUM_LANES   = 4;
   localparam int MAX_DIM     = 128;
   localparam int LANE_BITS   = 32 / NUM_LANES;
   localparam int POS_W       = $clog2(MAX_DIM);
   localparam int CNT_W       = $clog2(MAX_DIM + 1);

   // Field widths of the request and result channels.
   localparam int LANE_SEL_W  = 2;
   localparam int SHIFT_POS_W = 7;
   localparam int SAMPLE_W    = 32;
   localparam int HASH_W      = 32;
   localparam int REQ_FIELD_W = LANE_SEL_W + SHIFT_POS_W + SAMPLE_W;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;

   // Configuration registers.
   localparam int WIDTH_W     = 31;
   localparam int DIM_W       = 8;
   localparam int CSR_DATA_W  = WIDTH_W;
   localparam logic [WIDTH_W-1:0] BUCKET_WIDTH_RESET = 31'd262144000;
   localparam logic [DIM_W-1:0]   DIM_RESET          = 8'd128;

   // Divider: the shifted component is one bit wider than a sample.
   localparam int DIV_STEPS   = SAMPLE_W + 1;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   // Horner multiplier 2^32-5, reduced to one lane.
   localparam logic [31:0]          HASH_MULT = 32'hFFFF_FFFB;
   localparam logic [LANE_BITS-1:0] LANE_MULT = HASH_MULT[LANE_BITS-1:0];

   // Request queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      CSR_BUCKET_WIDTH = 1'b0,
      CSR_DIM_IN_USE   = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_FEED = 1'b1
   } item_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_START,
      BK_DIV,
      BK_UPDATE
   } back_state_type;

   typedef struct packed {
      item_kind_type                kind;
      logic [LANE_SEL_W-1:0]        lane_select;
      logic [SHIFT_POS_W-1:0]       shift_position;
      logic signed [SAMPLE_W-1:0]   sample_value;
   } req_item_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] bucket_width;
      logic [DIM_W-1:0]   dim_in_use;
   } cfg_type;

endpackage

// File: hw/rtl/lshg_div.sv
// Radix-2 restoring divider giving the low lane bits of a floored quotient.
// Depends on lshg_pkg.
module lshg_div
   import lshg_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [DIV_STEPS-1:0] num,
   input  logic [WIDTH_W-1:0]          den,
   output logic                        done,
   output logic [LANE_BITS-1:0]        quot_low
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   step_ff, step_in;
   logic                   neg_ff, neg_in;
   logic [WIDTH_W-1:0]     rem_ff, rem_in;
   logic [DIV_STEPS-1:0]   quo_ff, quo_in;
   logic [WIDTH_W-1:0]     den_ff, den_in;
   logic [WIDTH_W:0]       rem_sh;
   logic                   ge;
   logic [DIV_STEPS-1:0]   floor_q;

   // One quotient bit per cycle; the dividend shifts out as the quotient shifts in.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff, quo_ff[DIV_STEPS-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = num[DIV_STEPS-1];
         rem_in  = '0;
         quo_in  = num[DIV_STEPS-1] ? DIV_STEPS'(-num) : DIV_STEPS'(num);
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = ge ? WIDTH_W'(rem_sh - {1'b0, den_ff}) : WIDTH_W'(rem_sh);
         quo_in  = {quo_ff[DIV_STEPS-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   // Floor towards minus infinity: a negative dividend with a remainder rounds down by one.
   always_comb begin
      if (!neg_ff) begin
         floor_q = quo_ff;
      end else if (rem_ff != '0) begin
         floor_q = ~quo_ff;
      end else begin
         floor_q = -quo_ff;
      end
   end

   assign done     = done_ff;
   assign quot_low = floor_q[LANE_BITS-1:0];

endmodule

// File: hw/rtl/lshg_front.sv
// Front end: takes requests from the input channel, unpacks and classifies them.
// Depends on lshg_pkg.
module lshg_front
   import lshg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  item_valid,
   input  logic                  item_ready,
   output req_item_type          item
);

   logic         hold_valid_ff, hold_valid_in;
   req_item_type hold_ff, hold_in;
   logic         accept;

   // The holding register frees itself in the same cycle that the queue takes it.
   assign req_tready = !hold_valid_ff || item_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      hold_in                = hold_ff;
      hold_valid_in          = hold_valid_ff && !item_ready;
      if (accept) begin
         hold_valid_in          = 1'b1;
         hold_in.kind           = item_kind_type'(req_tuser);
         hold_in.lane_select    = req_tdata[LANE_SEL_W-1:0];
         hold_in.shift_position = req_tdata[LANE_SEL_W +: SHIFT_POS_W];
         hold_in.sample_value   = req_tdata[LANE_SEL_W + SHIFT_POS_W +: SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

   assign item_valid = hold_valid_ff;
   assign item       = hold_ff;

endmodule

// File: hw/rtl/lshg_queue.sv
// Short request queue that decouples the front end from the hashing back end.
// Depends on lshg_pkg.
module lshg_queue
   import lshg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  req_item_type push_item,
   output logic         pop_valid,
   input  logic         pop,
   output req_item_type pop_item
);

   req_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/lshg_back.sv
// Back end: shift table, one divider per lane, Horner hash lanes and the result register.
// Depends on lshg_pkg and lshg_div.
module lshg_back
   import lshg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              item_valid,
   output logic              item_pop,
   input  req_item_type      item,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [HASH_W-1:0] rsp_tdata
);

   back_state_type state_ff, state_in;

   // Shift table: one row per component position, one word per lane.
   logic [NUM_LANES-1:0][SAMPLE_W-1:0] shift_mem [MAX_DIM];
   logic [NUM_LANES-1:0][SAMPLE_W-1:0] row_ff;

   logic [NUM_LANES-1:0][LANE_BITS-1:0] hash_ff, hash_in, hash_next;
   logic [CNT_W-1:0]        count_ff, count_in, count_next, dim_eff;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0]       rsp_data_ff, rsp_data_in, hash_g;
   logic [POS_W-1:0]        read_pos;
   logic [WIDTH_W-1:0]      den;
   logic                    emit, out_free;
   logic                    mem_we, mem_re, div_start, commit;
   logic [NUM_LANES-1:0]    div_done;
   logic [NUM_LANES-1:0][LANE_BITS-1:0] div_quot;

   // Effective vector length and divisor after clamping.
   always_comb begin
      if (cfg.dim_in_use == '0) begin
         dim_eff = CNT_W'(1);
      end else if (cfg.dim_in_use > DIM_W'(MAX_DIM)) begin
         dim_eff = CNT_W'(MAX_DIM);
      end else begin
         dim_eff = CNT_W'(cfg.dim_in_use);
      end
   end
   assign den        = (cfg.bucket_width == '0) ? WIDTH_W'(1) : cfg.bucket_width;
   assign read_pos   = (count_ff < CNT_W'(MAX_DIM)) ? count_ff[POS_W-1:0]
                                                    : POS_W'(MAX_DIM - 1);
   assign count_next = count_ff + 1'b1;
   assign emit       = count_next >= dim_eff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (item_valid && item.kind == KIND_FEED) begin
               state_in = BK_START;
            end
         end
         BK_START:  state_in = BK_DIV;
         BK_DIV: begin
            if (div_done[0]) begin
               state_in = BK_UPDATE;
            end
         end
         BK_UPDATE: begin
            if (!emit || out_free) begin
               state_in = BK_IDLE;
            end
         end
         default:   state_in = BK_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      item_pop  = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      div_start = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            item_pop = item_valid;
            mem_we   = item_valid && item.kind == KIND_LOAD;
            mem_re   = item_valid && item.kind == KIND_FEED;
         end
         BK_START:  div_start = 1'b1;
         BK_DIV:    ;
         BK_UPDATE: commit = !emit || out_free;
         default:   ;
      endcase
   end

   // Table write on a load, row read on a component.
   always_ff @(posedge clock) begin
      if (mem_we && 32'(item.lane_select) < NUM_LANES
                 && 32'(item.shift_position) < MAX_DIM) begin
         shift_mem[item.shift_position][item.lane_select] <= item.sample_value;
      end
      if (mem_re) begin
         row_ff <= shift_mem[read_pos];
      end
   end

   // One floor divider per lane, all started together.
   for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
      logic signed [DIV_STEPS-1:0] diff;
      assign diff = DIV_STEPS'(sample_ff) - DIV_STEPS'($signed(row_ff[j]));
      lshg_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .num      (diff),
         .den      (den),
         .done     (div_done[j]),
         .quot_low (div_quot[j])
      );
   end

   // Horner fold of each lane and packing of the hash, lane zero highest.
   always_comb begin
      hash_g = '0;
      for (int j = 0; j < NUM_LANES; j++) begin
         hash_next[j] = LANE_BITS'(hash_ff[j] * LANE_MULT + div_quot[j]);
         hash_g[(NUM_LANES - 1 - j) * LANE_BITS +: LANE_BITS] = hash_next[j];
      end
   end

   // Commit of a component and loading of the result register.
   always_comb begin
      hash_in      = hash_ff;
      count_in     = count_ff;
      sample_in    = mem_re ? item.sample_value : sample_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (commit) begin
         if (emit) begin
            hash_in      = '0;
            count_in     = '0;
            rsp_data_in  = hash_g;
            rsp_valid_in = 1'b1;
         end else begin
            hash_in  = hash_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         hash_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hw/rtl/lsh_grid_shift_vector_hash_top.sv
// Top level of the grid shift vector hash: configuration registers and the
// front end, request queue and back end. Depends on lshg_pkg and all lshg_ modules.
//
//   Channel  Direction  Handshake            Contents
//   req_     in         tvalid/tready        tdata: lane_select, shift_position,
//                                            sample_value; tuser: opcode
//   rsp_     out        tvalid/tready        tdata: hash_g
//   csr_     in         we, no wait          index: register, wdata: value
//
// A load request is written to the shift table as the back end pops it. A component
// request passes through the table read, the divider start, 33 steps of the bit-serial
// divider in each lane, the divider done flag and the hash commit. The front end
// and a two-entry queue keep taking requests while the back end works or the
// result waits.
// Reset is synchronous; the shift table is not cleared and needs no clearing pass.
// A full result register stalls only the back end, at the commit of a vector.
module lsh_grid_shift_vector_hash_top
   import lshg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // lane_select, shift_position, sample_value, pad
   input  logic                  req_tuser,   // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [HASH_W-1:0]     rsp_tdata,   // hash_g
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   logic         front_valid, q_push_ready, q_valid, q_pop;
   req_item_type front_item, q_item;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BUCKET_WIDTH: cfg_in.bucket_width = csr_wdata[WIDTH_W-1:0];
            CSR_DIM_IN_USE:   cfg_in.dim_in_use   = csr_wdata[DIM_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bucket_width <= BUCKET_WIDTH_RESET;
         cfg_ff.dim_in_use   <= DIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lshg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (front_valid),
      .item_ready (q_push_ready),
      .item       (front_item)
   );

   lshg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (q_push_ready),
      .push_item  (front_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   lshg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (q_valid),
      .item_pop   (q_pop),
      .item       (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The back end never takes a request from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("back end popped an empty request queue");

   // An accepted request is held by the front end in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
                    (req_tvalid && req_tready) |=> front_valid)
      else $error("accepted request lost in the front end");

   // A full queue that is not drained stays full and refuses the front end.
   assert property (@(posedge clock) disable iff (reset)
                    (!q_push_ready && !q_pop) |=> (!q_push_ready && q_valid))
      else $error("request queue changed without a pop");

endmodule
